>>> hw/rtl/calendar_epoch_converter_assert.svh
// ============================================================================
// Assertion macros for the calendar epoch converter
// Concurrent assertion wrappers that can be compiled out with NO_ASSERTIONS.
// ============================================================================
`ifndef CALENDAR_EPOCH_CONVERTER_ASSERT_SVH
`define CALENDAR_EPOCH_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`ifndef NO_ASSERTIONS
`define CEC_ASSERT_SAME(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);
`else
`define CEC_ASSERT_SAME(label, clk, rst, lhs, rhs, msg)
`endif

// Next-cycle implication, disabled during reset.
`ifndef NO_ASSERTIONS
`define CEC_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);
`else
`define CEC_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg)
`endif

`endif

>>> hw/rtl/cec_pkg.sv
// ============================================================================
// Calendar epoch converter package
// Shared types, calendar constants and lookup functions.
// ============================================================================
package cec_pkg;

  // Width of the internal epoch accumulator; results wrap modulo 2^EPOCH_BITS.
  localparam int EPOCH_BITS = 32;

  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;

  localparam logic [11:0] BASE_YEAR     = 12'd1970;
  localparam logic [1:0]  BASE_MOD4     = 2'd2;
  localparam logic [6:0]  BASE_MOD100   = 7'd70;
  localparam logic [8:0]  BASE_MOD400   = 9'd370;
  localparam logic [6:0]  LAST_MOD100   = 7'd99;
  localparam logic [8:0]  LAST_MOD400   = 9'd399;
  localparam logic [3:0]  LAST_MONTH    = 4'd12;
  localparam logic [4:0]  LAST_HOUR     = 5'd23;
  localparam logic [5:0]  LAST_MINUTE   = 6'd59;
  localparam logic [5:0]  LAST_SECOND   = 6'd59;

  typedef enum logic {
    OP_TO_EPOCH   = 1'b0,
    OP_FROM_EPOCH = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_DAY,
    ST_HOUR,
    ST_MINUTE,
    ST_SECOND,
    ST_DONE
  } state_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic in_fire;
    logic in_from;
    logic in_bad;
    logic from_op;
    logic go;
    logic day_bad;
    logic out_free;
  } stat_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    state_t phase;
    logic   load;
    logic   step;
    logic   set_invalid;
    logic   finish;
  } ctrl_t;

  function automatic logic is_leap(input logic [1:0] mod4, input logic [6:0] mod100,
                                   input logic [8:0] mod400);
    return (mod400 == 9'd0) || ((mod4 == 2'd0) && (mod100 != 7'd0));
  endfunction

  // Length of a month in days; codes outside 1..12 give 30.
  function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
    logic [4:0] d;
    case (month) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd30;
    endcase
    return d;
  endfunction

  // Seconds in a month of the given day count.
  function automatic logic [EPOCH_BITS-1:0] days_to_secs(input logic [4:0] days);
    logic [EPOCH_BITS-1:0] s;
    case (days)
      5'd28:   s = EPOCH_BITS'(28 * SECS_PER_DAY);
      5'd29:   s = EPOCH_BITS'(29 * SECS_PER_DAY);
      5'd31:   s = EPOCH_BITS'(31 * SECS_PER_DAY);
      default: s = EPOCH_BITS'(30 * SECS_PER_DAY);
    endcase
    return s;
  endfunction

  function automatic logic [EPOCH_BITS-1:0] year_secs(input logic leap);
    return leap ? EPOCH_BITS'(366 * SECS_PER_DAY) : EPOCH_BITS'(365 * SECS_PER_DAY);
  endfunction

endpackage

>>> hw/rtl/cec_req_if.sv
// ============================================================================
// Calendar epoch converter request channel
// Valid/ready channel carrying one conversion request per beat.
// ============================================================================
interface cec_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [11:0] cal_year;
  logic [3:0]  cal_month;
  logic [4:0]  cal_day;
  logic [4:0]  cal_hour;
  logic [5:0]  cal_minute;
  logic [5:0]  cal_second;
  logic [31:0] epoch_in;

  modport source (
    output valid, operation, cal_year, cal_month, cal_day, cal_hour, cal_minute,
           cal_second, epoch_in,
    input  ready
  );

  modport sink (
    input  valid, operation, cal_year, cal_month, cal_day, cal_hour, cal_minute,
           cal_second, epoch_in,
    output ready
  );
endinterface

>>> hw/rtl/cec_rsp_if.sv
// ============================================================================
// Calendar epoch converter response channel
// Valid/ready channel carrying one conversion result per beat.
// ============================================================================
interface cec_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_out;
  logic        invalid;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;

  modport source (
    output valid, epoch_out, invalid, out_year, out_month, out_day, out_hour,
           out_minute, out_second,
    input  ready
  );

  modport sink (
    input  valid, epoch_out, invalid, out_year, out_month, out_day, out_hour,
           out_minute, out_second,
    output ready
  );
endinterface

>>> hw/rtl/cec_alu.sv
// ============================================================================
// Calendar epoch converter shared adder
// One adder that adds, or subtracts and reports whether the operand fit.
// ============================================================================
module cec_alu (
  input  logic [cec_pkg::EPOCH_BITS-1:0] a,
  input  logic [cec_pkg::EPOCH_BITS-1:0] b,
  input  logic                           sub,
  output logic [cec_pkg::EPOCH_BITS-1:0] y,
  output logic                           fits
);

  logic [cec_pkg::EPOCH_BITS-1:0] b_eff;
  logic [cec_pkg::EPOCH_BITS:0]   sum;

  assign b_eff = sub ? ~b : b;
  assign sum   = {1'b0, a} + {1'b0, b_eff} + {{cec_pkg::EPOCH_BITS{1'b0}}, sub};
  assign y     = sum[cec_pkg::EPOCH_BITS-1:0];
  // In subtract mode the carry out means no borrow, so a >= b.
  assign fits  = sum[cec_pkg::EPOCH_BITS];

endmodule

>>> hw/rtl/cec_ctrl.sv
// ============================================================================
// Calendar epoch converter sequencer
// Steps through the year, month, day, hour, minute and second phases.
// ============================================================================
module cec_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  cec_pkg::stat_t stat,
  output cec_pkg::ctrl_t ctrl
);

  cec_pkg::state_t state;
  cec_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cec_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cec_pkg::ST_IDLE: begin
        if (stat.in_fire) begin
          state_next = (!stat.in_from && stat.in_bad) ? cec_pkg::ST_DONE : cec_pkg::ST_YEAR;
        end
      end
      cec_pkg::ST_YEAR: begin
        if (!stat.go) begin
          state_next = (!stat.from_op && stat.day_bad) ? cec_pkg::ST_DONE : cec_pkg::ST_MONTH;
        end
      end
      cec_pkg::ST_MONTH:  if (!stat.go) state_next = cec_pkg::ST_DAY;
      cec_pkg::ST_DAY:    if (!stat.go) state_next = cec_pkg::ST_HOUR;
      cec_pkg::ST_HOUR:   if (!stat.go) state_next = cec_pkg::ST_MINUTE;
      cec_pkg::ST_MINUTE: if (!stat.go) state_next = cec_pkg::ST_SECOND;
      cec_pkg::ST_SECOND: state_next = cec_pkg::ST_DONE;
      cec_pkg::ST_DONE:   if (stat.out_free) state_next = cec_pkg::ST_IDLE;
      default:            state_next = cec_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl             = '0;
    ctrl.phase       = state;
    unique case (state) inside
      cec_pkg::ST_IDLE: begin
        ctrl.load        = stat.in_fire;
        ctrl.set_invalid = stat.in_fire && !stat.in_from && stat.in_bad;
      end
      cec_pkg::ST_YEAR: begin
        ctrl.step        = stat.go;
        ctrl.set_invalid = !stat.go && !stat.from_op && stat.day_bad;
      end
      cec_pkg::ST_MONTH, cec_pkg::ST_DAY, cec_pkg::ST_HOUR, cec_pkg::ST_MINUTE: begin
        ctrl.step = stat.go;
      end
      cec_pkg::ST_SECOND: ctrl.step   = !stat.from_op;
      cec_pkg::ST_DONE:   ctrl.finish = stat.out_free;
      default:            ctrl.step   = 1'b0;
    endcase
  end

endmodule

>>> hw/rtl/calendar_epoch_converter.sv
// ============================================================================
// Calendar epoch converter
// Converts between 32-bit Unix epoch seconds and Gregorian calendar fields.
// ============================================================================
// One request beat gives one response beat. The block takes a request only
// when its sequencer is idle and works on it alone; a finished result sits in
// the output register, so a new request can be taken while it waits. All epoch
// arithmetic goes through a single shared adder, one year, month, day, hour or
// minute per cycle. Calendar to epoch counts up from 1970 field by field, so late
// years are slow; rejected fields that need no date check go straight to the
// result, a bad day of month after the year walk. Epoch to calendar walks the
// remaining seconds down by whole years, months, days, hours and minutes.
// The year walk dominates the time in both directions.
// ============================================================================
module calendar_epoch_converter (
  input  logic      clk,
  input  logic      rst,
  cec_req_if.sink   req,
  cec_rsp_if.source rsp
);

  localparam int EB = cec_pkg::EPOCH_BITS;

  cec_pkg::stat_t stat;
  cec_pkg::ctrl_t ctrl;

  // Captured request fields.
  logic        op_q;
  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic [4:0]  hour_q;
  logic [5:0]  min_q;
  logic [5:0]  sec_q;
  logic        invalid_q;

  // Working registers: epoch accumulator and calendar counters.
  logic [EB-1:0] acc;
  logic [11:0]   cur_year;
  logic [1:0]    mod4;
  logic [6:0]    mod100;
  logic [8:0]    mod400;
  logic [3:0]    cur_month;
  logic [4:0]    day_cnt;
  logic [4:0]    hour_cnt;
  logic [5:0]    min_cnt;

  // Output register.
  logic        out_valid;
  logic [31:0] out_epoch;
  logic        out_invalid;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;

  logic          leap;
  logic          from_op;
  logic          in_bad;
  logic          go;
  logic [EB-1:0] operand;
  logic [EB-1:0] alu_y;
  logic          alu_fits;

  assign from_op = (op_q == cec_pkg::OP_FROM_EPOCH);
  assign leap    = cec_pkg::is_leap(mod4, mod100, mod400);

  // Field checks that do not depend on the year being leap.
  assign in_bad = (req.cal_year < cec_pkg::BASE_YEAR) || (req.cal_month == 4'd0) ||
                  (req.cal_month > cec_pkg::LAST_MONTH) || (req.cal_day == 5'd0) ||
                  (req.cal_hour > cec_pkg::LAST_HOUR) ||
                  (req.cal_minute > cec_pkg::LAST_MINUTE) ||
                  (req.cal_second > cec_pkg::LAST_SECOND);

  // Operand for the shared adder in each phase.
  always_comb begin
    case (ctrl.phase)
      cec_pkg::ST_YEAR:   operand = cec_pkg::year_secs(leap);
      cec_pkg::ST_MONTH:  operand = cec_pkg::days_to_secs(cec_pkg::days_in_month(cur_month, leap));
      cec_pkg::ST_DAY:    operand = EB'(cec_pkg::SECS_PER_DAY);
      cec_pkg::ST_HOUR:   operand = EB'(cec_pkg::SECS_PER_HOUR);
      cec_pkg::ST_MINUTE: operand = EB'(cec_pkg::SECS_PER_MIN);
      cec_pkg::ST_SECOND: operand = EB'(sec_q);
      default:            operand = '0;
    endcase
  end

  cec_alu u_alu (
    .a    (acc),
    .b    (operand),
    .sub  (from_op),
    .y    (alu_y),
    .fits (alu_fits)
  );

  // Whether the current phase takes another step. Calendar to epoch counts up
  // to the requested field; epoch to calendar steps while the unit still fits.
  always_comb begin
    case (ctrl.phase)
      cec_pkg::ST_YEAR:   go = from_op ? alu_fits : (cur_year < year_q);
      cec_pkg::ST_MONTH:  go = from_op ? (alu_fits && (cur_month != cec_pkg::LAST_MONTH))
                                       : (cur_month < month_q);
      cec_pkg::ST_DAY:    go = from_op ? alu_fits : ((day_cnt + 5'd1) < day_q);
      cec_pkg::ST_HOUR:   go = from_op ? alu_fits : (hour_cnt < hour_q);
      cec_pkg::ST_MINUTE: go = from_op ? alu_fits : (min_cnt < min_q);
      default:            go = 1'b0;
    endcase
  end

  always_comb begin
    stat.in_fire  = req.valid && req.ready;
    stat.in_from  = (req.operation == cec_pkg::OP_FROM_EPOCH);
    stat.in_bad   = in_bad;
    stat.from_op  = from_op;
    stat.go       = go;
    // At the end of the year walk the counters describe the requested year.
    stat.day_bad  = (day_q > cec_pkg::days_in_month(month_q, leap));
    stat.out_free = !out_valid || rsp.ready;
  end

  cec_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  assign req.ready = (ctrl.phase == cec_pkg::ST_IDLE);

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_q      <= req.operation;
      year_q    <= req.cal_year;
      month_q   <= req.cal_month;
      day_q     <= req.cal_day;
      hour_q    <= req.cal_hour;
      min_q     <= req.cal_minute;
      sec_q     <= req.cal_second;
      acc       <= (req.operation == cec_pkg::OP_FROM_EPOCH) ? EB'(req.epoch_in) : '0;
      cur_year  <= cec_pkg::BASE_YEAR;
      mod4      <= cec_pkg::BASE_MOD4;
      mod100    <= cec_pkg::BASE_MOD100;
      mod400    <= cec_pkg::BASE_MOD400;
      cur_month <= 4'd1;
      day_cnt   <= 5'd0;
      hour_cnt  <= 5'd0;
      min_cnt   <= 6'd0;
    end else if (ctrl.step) begin
      acc <= alu_y;
      case (ctrl.phase)
        cec_pkg::ST_YEAR: begin
          cur_year <= cur_year + 12'd1;
          mod4     <= mod4 + 2'd1;
          mod100   <= (mod100 == cec_pkg::LAST_MOD100) ? 7'd0 : mod100 + 7'd1;
          mod400   <= (mod400 == cec_pkg::LAST_MOD400) ? 9'd0 : mod400 + 9'd1;
        end
        cec_pkg::ST_MONTH:  cur_month <= cur_month + 4'd1;
        cec_pkg::ST_DAY:    day_cnt   <= day_cnt + 5'd1;
        cec_pkg::ST_HOUR:   hour_cnt  <= hour_cnt + 5'd1;
        cec_pkg::ST_MINUTE: min_cnt   <= min_cnt + 6'd1;
        default:            cur_month <= cur_month;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      invalid_q <= ctrl.set_invalid;
    end else if (ctrl.set_invalid) begin
      invalid_q <= 1'b1;
    end
  end

  // Output register: a finished result waits here until the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      if (from_op) begin
        out_epoch   <= 32'd0;
        out_invalid <= 1'b0;
        out_year    <= cur_year;
        out_month   <= cur_month;
        out_day     <= day_cnt + 5'd1;
        out_hour    <= hour_cnt;
        out_minute  <= min_cnt;
        out_second  <= acc[5:0];
      end else begin
        out_epoch   <= invalid_q ? 32'd0 : acc[31:0];
        out_invalid <= invalid_q;
        out_year    <= 12'd0;
        out_month   <= 4'd0;
        out_day     <= 5'd0;
        out_hour    <= 5'd0;
        out_minute  <= 6'd0;
        out_second  <= 6'd0;
      end
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.epoch_out  = out_epoch;
  assign rsp.invalid    = out_invalid;
  assign rsp.out_year   = out_year;
  assign rsp.out_month  = out_month;
  assign rsp.out_day    = out_day;
  assign rsp.out_hour   = out_hour;
  assign rsp.out_minute = out_minute;
  assign rsp.out_second = out_second;

`include "calendar_epoch_converter_assert.svh"

  // A request beat always starts work, so the block is busy in the next cycle.
  `CEC_ASSERT_NEXT(a_accept_busy, clk, rst, req.valid && req.ready, !req.ready, "accept did not start work")

  // Finishing always presents a result beat in the next cycle.
  `CEC_ASSERT_NEXT(a_finish_shows, clk, rst, ctrl.finish, rsp.valid, "finished result not shown")

  // A rejected request never carries an epoch value.
  `CEC_ASSERT_SAME(a_invalid_zero, clk, rst, rsp.valid && rsp.invalid, rsp.epoch_out == 32'd0 && rsp.out_year == 12'd0, "rejected beat carries data")

  // A decoded date always has a month in range.
  `CEC_ASSERT_SAME(a_month_range, clk, rst, rsp.valid && (rsp.out_year != 12'd0), (rsp.out_month != 4'd0) && (rsp.out_month <= cec_pkg::LAST_MONTH), "decoded month out of range")

endmodule
